[hw/rtl/wufcg_pkg.sv]
// ----------------------------------------------------------------------------
// wufcg_pkg
// Shared types and constants for the weighted union-find cycle gcd block.
// ----------------------------------------------------------------------------
package wufcg_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int NODE_W         = 10;
  localparam int OFF_W          = 12;
  localparam int GCD_W          = 11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F1_RD,
    ST_F1_CHK,
    ST_F2_RD,
    ST_F2_CHK,
    ST_JOIN,
    ST_MIS,
    ST_GCD,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/weighted_union_find_cycle_gcd.sv]
// ----------------------------------------------------------------------------
// weighted_union_find_cycle_gcd
// Union-find with parent offsets over directed edges; running gcd of cycle
// mismatches.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  input   | in_src_node, in_dst_node       | start high while busy low
//  result  | out_joined, out_cycle_gcd      | out_valid, one cycle, no stall
//
// Per endpoint the root walk reads and checks one parent per step, and the
// compression pass reads and relinks each path node; single-port node RAMs
// serialize these accesses. Then a join or mismatch state follows; a nonzero
// mismatch runs subtractive Euclid, one subtract or swap per step. A done
// state closes the item; out_valid is high in the cycle after. After reset all
// nodes are cleared with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module weighted_union_find_cycle_gcd #(
  parameter int NODE_COUNT = wufcg_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [wufcg_pkg::NODE_W-1:0] in_src_node,
  input  logic [wufcg_pkg::NODE_W-1:0] in_dst_node,
  output logic                       out_valid,
  output logic                       out_joined,
  output logic [wufcg_pkg::GCD_W-1:0] out_cycle_gcd
);
  import wufcg_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = AW + 1;

  // reciprocal constants for reducing a node index modulo NODE_COUNT
  localparam int RED_S  = NODE_W + AW;
  localparam int RED_MW = NODE_W + 2;
  localparam longint RED_M_FULL =
    ((longint'(1) << RED_S) + longint'(NODE_COUNT) - longint'(1)) / longint'(NODE_COUNT);
  localparam logic [RED_MW-1:0] RED_M = RED_MW'(RED_M_FULL);

  state_t state_r, state_nxt;

  logic          clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] a_node_r, a_node_nxt;   // source node
  logic [AW-1:0] b_node_r, b_node_nxt;   // destination node
  logic          side_r, side_nxt;       // 0: source find, 1: destination
  logic [AW-1:0] cur_r, cur_nxt;
  logic [OFF_W-1:0] sum_r, sum_nxt;
  logic [OFF_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic [AW-1:0] rs_r, rs_nxt;
  logic [OFF_W-1:0] ps_r, ps_nxt;
  logic [GCD_W-1:0] g_r, g_nxt;
  logic [GCD_W-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic          joined_r, joined_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [AW-1:0] par_wd, par_rd;
  logic [OFF_W-1:0] off_wd, off_rd;

  logic [OFF_W-1:0] mis;
  logic [OFF_W-1:0] mag;
  logic [GCD_W-1:0] mag_sat;
  logic [CW-1:0]    node_cnt;
  logic [AW-1:0]    src_red;
  logic [AW-1:0]    dst_red;

  // x mod NODE_COUNT by multiply with the rounded-up reciprocal
  function automatic logic [AW-1:0] node_mod(input logic [NODE_W-1:0] x);
    logic [NODE_W+RED_MW-1:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = (NODE_W+RED_MW)'(x) * (NODE_W+RED_MW)'(RED_M);
    q = 32'(prod >> RED_S);
    r = 32'(x) - q * 32'(NODE_COUNT);
    return r[AW-1:0];
  endfunction

  assign node_cnt = CW'(NODE_COUNT);
  assign src_red  = node_mod(in_src_node);
  assign dst_red  = node_mod(in_dst_node);

  wufcg_ram #(.WIDTH(AW), .DEPTH(2**AW)) u_par (
    .clk(clk), .we(we), .addr(addr), .wdata(par_wd), .rdata(par_rd)
  );
  wufcg_ram #(.WIDTH(OFF_W), .DEPTH(2**AW)) u_off (
    .clk(clk), .we(we), .addr(addr), .wdata(off_wd), .rdata(off_rd)
  );

  // Mismatch ps - pd + 1 in 12-bit two's complement, then magnitude.
  assign mis = ps_r - sum_r + OFF_W'(1);
  assign mag = mis[OFF_W-1] ? (~mis + OFF_W'(1)) : mis;
  assign mag_sat = (mag > OFF_W'(2047)) ? GCD_W'(2047) : mag[GCD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      clr_r    <= 1'b1;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
      g_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
      g_r      <= g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_node_r <= a_node_nxt;
    b_node_r <= b_node_nxt;
    side_r   <= side_nxt;
    cur_r    <= cur_nxt;
    sum_r    <= sum_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    rs_r     <= rs_nxt;
    ps_r     <= ps_nxt;
    ga_r     <= ga_nxt;
    gb_r     <= gb_nxt;
    joined_r <= joined_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    a_node_nxt = a_node_r;
    b_node_nxt = b_node_r;
    side_nxt   = side_r;
    cur_nxt    = cur_r;
    sum_nxt    = sum_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    rs_nxt     = rs_r;
    ps_nxt     = ps_r;
    g_nxt      = g_r;
    ga_nxt     = ga_r;
    gb_nxt     = gb_r;
    joined_nxt = joined_r;
    ov_nxt     = 1'b0;
    we         = 1'b0;
    addr       = cur_r;
    par_wd     = root_r;
    off_wd     = rem_r;

    case (state_r)
      ST_IDLE: begin
        if (clr_r) begin
          // clear pass: each node points to itself with zero offset
          we     = 1'b1;
          addr   = cnt_r[AW-1:0];
          par_wd = cnt_r[AW-1:0];
          off_wd = '0;
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == node_cnt - CW'(1)) begin
            clr_nxt = 1'b0;
          end
        end else if (start) begin
          a_node_nxt = src_red;
          b_node_nxt = dst_red;
          cur_nxt    = src_red;
          side_nxt   = 1'b0;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_F1_RD;
        end
      end
      ST_F1_RD: begin
        addr = cur_r;
        state_nxt = ST_F1_CHK;
      end
      ST_F1_CHK: begin
        if (par_rd == cur_r || cnt_r == node_cnt) begin
          root_nxt  = cur_r;
          rem_nxt   = sum_r;
          cur_nxt   = side_r ? b_node_r : a_node_r;
          cnt_nxt   = '0;
          state_nxt = ST_F2_RD;
        end else begin
          sum_nxt   = sum_r + off_rd;
          cur_nxt   = par_rd;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_F1_RD;
        end
      end
      ST_F2_RD: begin
        addr = cur_r;
        if (cur_r == root_r || cnt_r == node_cnt) begin
          if (!side_r) begin
            rs_nxt    = root_r;
            ps_nxt    = sum_r;
            side_nxt  = 1'b1;
            cur_nxt   = b_node_r;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_F1_RD;
          end else if (rs_r != root_r) begin
            state_nxt = ST_JOIN;
          end else begin
            state_nxt = ST_MIS;
          end
        end else begin
          state_nxt = ST_F2_CHK;
        end
      end
      ST_F2_CHK: begin
        // relink to root, advance along the old parent
        we        = 1'b1;
        addr      = cur_r;
        par_wd    = root_r;
        off_wd    = rem_r;
        rem_nxt   = rem_r - off_rd;
        cur_nxt   = par_rd;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = ST_F2_RD;
      end
      ST_JOIN: begin
        we         = 1'b1;
        addr       = rs_r;
        par_wd     = root_r;
        off_wd     = sum_r - ps_r - OFF_W'(1);
        joined_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_MIS: begin
        joined_nxt = 1'b0;
        if (mag_sat == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ga_nxt    = g_r;
          gb_nxt    = mag_sat;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        // subtractive Euclid: reduce a below b, then swap
        if (gb_r == '0) begin
          g_nxt     = ga_r;
          state_nxt = ST_DONE;
        end else if (ga_r >= gb_r) begin
          ga_nxt = ga_r - gb_r;
        end else begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy          = (state_r != ST_IDLE) || clr_r;
  assign out_valid     = ov_r;
  assign out_joined    = joined_r;
  assign out_cycle_gcd = g_r;

endmodule

[hw/rtl/wufcg_ram.sv]
// ----------------------------------------------------------------------------
// wufcg_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module wufcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
